[rtl/tiled_sprite_list_generator_top_macros.svh]
// assertion helpers for the checker file
`ifndef TILED_SPRITE_LIST_GENERATOR_TOP_MACROS_SVH
`define TILED_SPRITE_LIST_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TSLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TSLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tslg_pkg.sv]
package tslg_pkg;

    // field widths
    localparam int ADDR_W   = 16;
    localparam int POS_W    = 10;
    localparam int SPEED_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int DIM_W    = 4;
    localparam int TILE_W   = 6;
    localparam int ALU_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 64;

    // constants of the sprite entry
    localparam logic [BYTE_W-1:0] ATTR_BYTE  = 8'h0c;
    localparam logic [POS_W-1:0]  RESET_Y    = 10'd240;
    localparam logic [POS_W-1:0]  TILE_BASE  = 10'd8;
    localparam int                MAX_TILES_DEF = 64;

    // output tdata bit offsets
    localparam int OFS_ADDR = 0;
    localparam int OFS_X    = 16;
    localparam int OFS_Y    = 26;
    localparam int OFS_ATTR = 36;
    localparam int OFS_SPEC = 44;
    localparam int OFS_TILE = 52;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 3'd5;

    // input kinds
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] step;
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [BYTE_W-1:0] spec;
        logic [POS_W-1:0]  left;
    } t_cfg;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             borrow;
    } t_alu_rsp;

endpackage

[rtl/tslg_alu.sv]
module tslg_alu (
    input  tslg_pkg::t_alu_req i_req,
    output tslg_pkg::t_alu_rsp o_rsp
);
    import tslg_pkg::*;

    logic [ALU_W:0] w_full;
    logic [ALU_W-1:0] w_b;

    // shared adder: subtract as a plus inverted b plus one
    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + (ALU_W+1)'(i_req.sub);

    // borrow only has meaning for a subtraction
    assign o_rsp.sum    = w_full[ALU_W-1:0];
    assign o_rsp.borrow = i_req.sub & ~w_full[ALU_W];

endmodule

[rtl/tslg_cfg.sv]
module tslg_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tslg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tslg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output tslg_pkg::t_cfg                     o_cfg
);
    import tslg_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base <= '0;
            r_cfg.step <= '0;
            r_cfg.cols <= DIM_W'(1);
            r_cfg.rows <= DIM_W'(1);
            r_cfg.spec <= '0;
            r_cfg.left <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:    r_cfg.base <= i_cfg_data[ADDR_W-1:0];
                CFG_STEP:    r_cfg.step <= i_cfg_data[ADDR_W-1:0];
                CFG_COLUMNS: r_cfg.cols <= i_cfg_data[DIM_W-1:0];
                CFG_ROWS:    r_cfg.rows <= i_cfg_data[DIM_W-1:0];
                CFG_SPEC:    r_cfg.spec <= i_cfg_data[BYTE_W-1:0];
                CFG_LEFT:    r_cfg.left <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/tiled_sprite_list_generator_top.sv]
// Tiled sprite list generator.
// Input stream (s_axis): one transaction per frame tick or motion load. tuser
// selects the kind: a load sets position, speed and target on acceptance and
// gives no entries; a tick moves the block toward its target, then emits one
// sprite entry per tile on the output stream (m_axis), tlast on the final one.
// Configuration goes through the plain write port, which the user must write
// only while the block is idle; the block itself does not enforce this. One
// shared 16-bit add/subtract unit does the motion, address and position
// adds. A tick runs the motion steps (distance, absolute value if needed,
// compare, move if needed; none at speed zero), a setup step, then per tile
// an emit, an address add and a position add, only the emit for the last
// tile. s_axis_tready is high only between items.
// Results leave through an output register; a stalled receiver holds the
// sequencer in its emit step, and the last entry may still wait in the
// output register while the next item is taken.
// Reset (synchronous, active low) returns registers to their defaults, sets
// the position to 240 with speed and target zero, and empties the output.
module tiled_sprite_list_generator_top #(
    parameter int MAX_TILES = tslg_pkg::MAX_TILES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // new_y[9:0], new_speed[17:10], new_target[27:18], zero fill
    input  logic [tslg_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sprite_address[15:0], sprite_x[25:16], sprite_y[35:26],
    // attribute_byte[43:36], spec_byte[51:44], tile_number[57:52], zero fill
    output logic [tslg_pkg::M_DATA_W-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [tslg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tslg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tslg_pkg::*;

    localparam int CNT_W = $clog2(MAX_TILES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIST, S_ABS, S_CMP, S_MOVE, S_INIT, S_EMIT, S_POS
    } t_state;

    t_cfg     w_cfg;
    t_alu_req w_req;
    t_alu_rsp w_rsp;

    t_state             r_state;
    logic [POS_W-1:0]   r_cur_y;
    logic [SPEED_W-1:0] r_speed;
    logic [POS_W-1:0]   r_target;
    logic               r_below;
    logic [POS_W-1:0]   r_dist;
    logic [ADDR_W-1:0]  r_addr;
    logic [POS_W-1:0]   r_x;
    logic [POS_W-1:0]   r_y;
    logic [DIM_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_tile;
    logic [CNT_W-1:0]   r_ntiles;
    logic               r_addr_done;
    logic               r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic               r_out_last;

    logic [2*DIM_W-1:0] w_prod;
    logic [CNT_W-1:0]   w_ntiles;
    logic [POS_W-1:0]   w_tile_w;
    logic [POS_W-1:0]   w_tile_h;
    logic               w_last;
    logic               w_row_end;
    logic               w_out_free;
    logic               w_in_acc;

    tslg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tslg_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // tile count saturated at the maximum
    assign w_prod   = {{DIM_W{1'b0}}, w_cfg.cols} * {{DIM_W{1'b0}}, w_cfg.rows};
    assign w_ntiles = (w_prod > (2*DIM_W)'(MAX_TILES)) ? CNT_W'(MAX_TILES)
                                                       : CNT_W'(w_prod);

    // tile size from the spec codes
    assign w_tile_w = TILE_BASE << w_cfg.spec[5:4];
    assign w_tile_h = TILE_BASE << w_cfg.spec[7:6];

    assign w_last     = (r_tile == r_ntiles - CNT_W'(1));
    assign w_row_end  = (r_col == w_cfg.cols - DIM_W'(1));
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;

    // operand selection for the shared unit
    always_comb begin
        w_req = '{a: '0, b: '0, sub: 1'b0};
        case (r_state)
            S_DIST: w_req = '{a: ALU_W'(r_cur_y), b: ALU_W'(r_target), sub: 1'b1};
            S_ABS:  w_req = '{a: ALU_W'(r_target), b: ALU_W'(r_cur_y), sub: 1'b1};
            S_CMP:  w_req = '{a: ALU_W'(r_speed), b: ALU_W'(r_dist), sub: 1'b1};
            S_MOVE: w_req = '{a: ALU_W'(r_cur_y), b: ALU_W'(r_speed), sub: !r_below};
            S_POS: begin
                if (!r_addr_done) begin
                    w_req = '{a: r_addr, b: w_cfg.step, sub: 1'b0};
                end else if (w_row_end) begin
                    w_req = '{a: ALU_W'(r_y), b: ALU_W'(w_tile_h), sub: 1'b0};
                end else begin
                    w_req = '{a: ALU_W'(r_x), b: ALU_W'(w_tile_w), sub: 1'b0};
                end
            end
            default: ;
        endcase
    end

    // sequencer, motion state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_y     <= RESET_Y;
            r_speed     <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output valid: set on emit, cleared once taken
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser == FUNC_LOAD) begin
                            r_cur_y  <= s_axis_tdata[9:0];
                            r_speed  <= s_axis_tdata[17:10];
                            r_target <= s_axis_tdata[27:18];
                        end else if (r_speed == '0) begin
                            r_state <= S_INIT;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    r_dist  <= w_rsp.sum[POS_W-1:0];
                    r_below <= w_rsp.borrow;
                    r_state <= w_rsp.borrow ? S_ABS : S_CMP;
                end
                S_ABS: begin
                    r_dist  <= w_rsp.sum[POS_W-1:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // within one step: snap and stop
                    if (!w_rsp.borrow) begin
                        r_cur_y <= r_target;
                        r_speed <= '0;
                        r_state <= S_INIT;
                    end else begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_cur_y <= w_rsp.sum[POS_W-1:0];
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_addr   <= w_cfg.base;
                    r_x      <= w_cfg.left;
                    r_y      <= r_cur_y;
                    r_col    <= '0;
                    r_tile   <= '0;
                    r_ntiles <= w_ntiles;
                    r_state  <= (w_ntiles == '0) ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_last  <= w_last;
                        r_out_data  <= M_DATA_W'({TILE_W'(r_tile), w_cfg.spec, ATTR_BYTE,
                                                  r_y, r_x, r_addr});
                        r_addr_done <= 1'b0;
                        r_state     <= w_last ? S_IDLE : S_POS;
                    end
                end
                S_POS: begin
                    // address first, then x or y on the shared unit
                    if (!r_addr_done) begin
                        r_addr      <= w_rsp.sum;
                        r_addr_done <= 1'b1;
                    end else begin
                        if (w_row_end) begin
                            r_col <= '0;
                            r_x   <= w_cfg.left;
                            r_y   <= w_rsp.sum[POS_W-1:0];
                        end else begin
                            r_col <= r_col + DIM_W'(1);
                            r_x   <= w_rsp.sum[POS_W-1:0];
                        end
                        r_tile  <= r_tile + CNT_W'(1);
                        r_state <= S_EMIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/tslg_checker.sv]
`include "tiled_sprite_list_generator_top_macros.svh"

module tslg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tslg_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input logic                             m_axis_tlast
);
    import tslg_pkg::*;

    // a stalled entry stays put
    `TSLG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output entry changed")

    // every entry carries the fixed attribute byte
    `TSLG_ASSERT_NOW(a_attr_fixed, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[OFS_ATTR +: BYTE_W] == ATTR_BYTE, "attribute byte is not 0x0c")

    // a frame tick keeps the block busy in the next cycle
    `TSLG_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_TICK), !s_axis_tready, "ready after frame tick transaction")

    // a motion load finishes at once
    `TSLG_ASSERT_NEXT(a_load_quick, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD), s_axis_tready, "not ready after motion load transaction")

endmodule

bind tiled_sprite_list_generator_top tslg_checker u_tslg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tslg_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RX_HOLD_CYCLES = 500;
    localparam int QUIET_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    // indexes outside the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic              func;
        logic [POS_W-1:0]  target;
        logic [SPEED_W-1:0] speed;
        logic [POS_W-1:0]  y;
        logic              drain_first;
    } t_motion_item;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [BYTE_W-1:0] attr;
        logic [BYTE_W-1:0] spec;
        logic [TILE_W-1:0] tile;
        logic              last;
    } t_sprite_entry;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the register file
    logic [ADDR_W-1:0]  cfg_base;
    logic [ADDR_W-1:0]  cfg_step;
    logic [DIM_W-1:0]   cfg_cols;
    logic [DIM_W-1:0]   cfg_rows;
    logic [BYTE_W-1:0]  cfg_spec;
    logic [POS_W-1:0]   cfg_left;

    // shadow of the motion state
    logic [POS_W-1:0]   mot_y;
    logic [SPEED_W-1:0] mot_speed;
    logic [POS_W-1:0]   mot_target;

    t_motion_item  item_queue[$];
    t_sprite_entry entry_expect_q[$];
    t_motion_item  next_item;
    t_sprite_entry exp_entry;
    t_sprite_entry got_entry;

    int unsigned mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          stall_cycles = 0;
    int          rx_hold_left = 0;
    bit          rx_hold_req = 1'b0;
    bit          rx_hold_ack = 1'b0;

    tiled_sprite_list_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply a motion load, or move toward the target and list one entry per tile
    task automatic expand_sprite_block(input logic kind,
                                       input logic [S_DATA_W-1:0] payload);
        int            gap;
        int            n_tiles;
        int            tile_w;
        int            tile_h;
        int            col;
        logic [ADDR_W-1:0] addr;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        t_sprite_entry e;
        if (kind == FUNC_LOAD) begin
            mot_y      = payload[POS_W-1:0];
            mot_speed  = payload[POS_W +: SPEED_W];
            mot_target = payload[POS_W+SPEED_W +: POS_W];
            return;
        end
        if (mot_speed != '0) begin
            gap = (mot_y >= mot_target) ? int'(mot_y) - int'(mot_target)
                                        : int'(mot_target) - int'(mot_y);
            if (gap <= int'(mot_speed)) begin
                mot_speed = '0;
                mot_y     = mot_target;
            end else if (mot_y < mot_target) begin
                mot_y = mot_y + POS_W'(mot_speed);
            end else begin
                mot_y = mot_y - POS_W'(mot_speed);
            end
        end
        n_tiles = int'(cfg_cols) * int'(cfg_rows);
        if (n_tiles > MAX_TILES_DEF) n_tiles = MAX_TILES_DEF;
        tile_h = 8 << cfg_spec[7:6];
        tile_w = 8 << cfg_spec[5:4];
        addr = cfg_base;
        x    = cfg_left;
        y    = mot_y;
        col  = 0;
        for (int i = 0; i < n_tiles; i++) begin
            e.addr = addr;
            e.x    = x;
            e.y    = y;
            e.attr = ATTR_BYTE;
            e.spec = cfg_spec;
            e.tile = TILE_W'(i);
            e.last = (i == n_tiles - 1);
            entry_expect_q.push_back(e);
            addr = addr + cfg_step;
            col++;
            if (col == int'(cfg_cols)) begin
                col = 0;
                x   = cfg_left;
                y   = y + POS_W'(tile_h);
            end else begin
                x = x + POS_W'(tile_w);
            end
        end
    endtask

    // sender: feeds motion and tick items from the queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expand_sprite_block(s_axis_tuser, s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (item_queue.size() != 0
                        && (!item_queue[0].drain_first || entry_expect_q.size() == 0)
                        && $urandom_range(99) >= tx_idle_pct) begin
                    next_item = item_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_item.func;
                    s_axis_tdata  <= S_DATA_W'({next_item.target, next_item.speed,
                                                next_item.y});
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random backpressure, long hold on request, entry check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_entry.addr = m_axis_tdata[OFS_ADDR +: ADDR_W];
                got_entry.x    = m_axis_tdata[OFS_X +: POS_W];
                got_entry.y    = m_axis_tdata[OFS_Y +: POS_W];
                got_entry.attr = m_axis_tdata[OFS_ATTR +: BYTE_W];
                got_entry.spec = m_axis_tdata[OFS_SPEC +: BYTE_W];
                got_entry.tile = m_axis_tdata[OFS_TILE +: TILE_W];
                got_entry.last = m_axis_tlast;
                if (entry_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected entry: addr=%h x=%0d y=%0d tile=%0d last=%b",
                                 got_entry.addr, got_entry.x, got_entry.y,
                                 got_entry.tile, got_entry.last);
                end else begin
                    exp_entry = entry_expect_q.pop_front();
                    if (got_entry != exp_entry) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display({"entry mismatch expected: addr=%h x=%0d y=%0d ",
                                      "attr=%h spec=%h tile=%0d last=%b"},
                                     exp_entry.addr, exp_entry.x, exp_entry.y,
                                     exp_entry.attr, exp_entry.spec, exp_entry.tile,
                                     exp_entry.last);
                            $display({"               actual:   addr=%h x=%0d y=%0d ",
                                      "attr=%h spec=%h tile=%0d last=%b"},
                                     got_entry.addr, got_entry.x, got_entry.y,
                                     got_entry.attr, got_entry.spec, got_entry.tile,
                                     got_entry.last);
                        end
                    end
                end
            end
            if (rx_hold_req != rx_hold_ack) begin
                rx_hold_ack   <= rx_hold_req;
                rx_hold_left  <= RX_HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_left != 0) begin
                rx_hold_left  <= rx_hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: no transaction for too long while work is outstanding
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (item_queue.size() == 0 && entry_expect_q.size() == 0
                        && !s_axis_tvalid)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            IDLE_TX:   begin tx_idle_pct = 82; rx_idle_pct = 0;  end
            IDLE_RX:   begin tx_idle_pct = 0;  rx_idle_pct = 82; end
            default:   begin tx_idle_pct = 13; rx_idle_pct = 13; end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_BASE:    cfg_base = data[ADDR_W-1:0];
            CFG_STEP:    cfg_step = data[ADDR_W-1:0];
            CFG_COLUMNS: cfg_cols = data[DIM_W-1:0];
            CFG_ROWS:    cfg_rows = data[DIM_W-1:0];
            CFG_SPEC:    cfg_spec = data[BYTE_W-1:0];
            CFG_LEFT:    cfg_left = data[POS_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] base, step, cols, rows,
                                 spec, left);
        write_reg(CFG_BASE, base);
        write_reg(CFG_STEP, step);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_SPEC, spec);
        write_reg(CFG_LEFT, left);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_load(input int y, speed, target, input bit drain);
        t_motion_item it;
        it.func        = FUNC_LOAD;
        it.y           = POS_W'(y);
        it.speed       = SPEED_W'(speed);
        it.target      = POS_W'(target);
        it.drain_first = drain;
        item_queue.push_back(it);
    endtask

    // tick payload bits are don't-care, so fill them with noise
    task automatic push_tick(input bit drain);
        t_motion_item it;
        it.func        = FUNC_TICK;
        it.y           = POS_W'($urandom());
        it.speed       = SPEED_W'($urandom());
        it.target      = POS_W'($urandom());
        it.drain_first = drain;
        item_queue.push_back(it);
    endtask

    // motion loads followed by runs of ticks, occasional full drain
    task automatic queue_random_items(input int count);
        int y;
        int speed;
        int target;
        int pick;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 30) begin
                y    = $urandom_range(1023);
                pick = $urandom_range(9);
                if (pick == 0)      speed = 0;
                else if (pick == 1) speed = 255;
                else if (pick < 6)  speed = $urandom_range(40, 1);
                else                speed = $urandom_range(255);
                if ($urandom_range(1) == 0) target = $urandom_range(1023);
                else target = (y + $urandom_range(240) - 120) & 10'h3ff;
                push_load(y, speed, target, $urandom_range(19) == 0);
            end else begin
                push_tick($urandom_range(19) == 0);
            end
        end
    endtask

    // dimensions mostly small, now and then zero or the largest
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int r;
        logic [CFG_DATA_W-1:0] d;
        r = $urandom_range(19);
        d = CFG_DATA_W'($urandom());
        if (r == 0)      d[DIM_W-1:0] = '0;
        else if (r == 1) d[DIM_W-1:0] = 4'd15;
        else             d[DIM_W-1:0] = DIM_W'($urandom_range(4, 1));
        return d;
    endfunction

    // wait until nothing is pending or in flight for a while
    task automatic wait_quiet(input int cycles);
        int quiet;
        quiet = 0;
        while (quiet < cycles) begin
            @(posedge i_clk);
            if (item_queue.size() == 0 && entry_expect_q.size() == 0 && !s_axis_tvalid)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    initial begin
        cfg_base   = '0;
        cfg_step   = '0;
        cfg_cols   = 4'd1;
        cfg_rows   = 4'd1;
        cfg_spec   = '0;
        cfg_left   = '0;
        mot_y      = RESET_Y;
        mot_speed  = '0;
        mot_target = '0;
        set_idle(IDLE_NONE);
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers, motion corner cases on a single tile
        push_tick(1'b0);
        push_load(0, 255, 1023, 1'b1);
        repeat (6) push_tick(1'b0);
        push_load(1023, 1, 0, 1'b0);
        push_tick(1'b0);
        push_load(500, 20, 520, 1'b0);
        push_tick(1'b0);
        push_load(600, 100, 550, 1'b1);
        push_tick(1'b0);
        push_load(300, 0, 900, 1'b0);
        push_tick(1'b0);
        push_load(1023, 255, 1023, 1'b0);
        push_tick(1'b0);
        push_load(100, 7, 0, 1'b1);
        push_tick(1'b0);
        push_tick(1'b0);
        wait_quiet(QUIET_CYCLES);

        // all-ones registers: saturated tile count, wrap of x, y and address
        write_reg(CFG_SPARE_6, 16'hffff);
        write_reg(CFG_SPARE_7, 16'h0000);
        set_registers(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_load(1020, 0, 0, 1'b0);
        push_tick(1'b0);
        push_load(1000, 255, 10, 1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b0);
        wait_quiet(QUIET_CYCLES);

        // long receiver hold while the sender keeps offering
        @(posedge i_clk);
        rx_hold_req <= ~rx_hold_req;
        queue_random_items(25);
        wait_quiet(QUIET_CYCLES);

        // zero columns: ticks move but list nothing
        set_registers(16'h0000, 16'h0000, 16'h0000, 16'h0005, 16'h0000, 16'h0000);
        set_idle(IDLE_TX);
        queue_random_items(15);
        wait_quiet(QUIET_CYCLES);

        // exactly the tile limit, zero base and step
        set_registers(16'h0000, 16'h0000, 16'h0008, 16'h0008, 16'h0000, 16'h0000);
        set_idle(IDLE_BOTH);
        queue_random_items(20);
        wait_quiet(QUIET_CYCLES);

        // random register settings across all idle modes
        for (int p = 0; p < 6; p++) begin
            set_registers(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), pick_dim(),
                          pick_dim(), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
            set_idle(t_idle_mode'(p % 4));
            queue_random_items(28);
            wait_quiet(QUIET_CYCLES);
        end

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && entry_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[tiled_sprite_list_generator_top.f]
+incdir+rtl
rtl/tslg_pkg.sv
rtl/tslg_alu.sv
rtl/tslg_cfg.sv
rtl/tiled_sprite_list_generator_top.sv
rtl/tslg_checker.sv
dv/tb.sv
